### design/bopm_pkg.sv
`default_nettype none

package bopm_pkg;

  localparam int unsigned DIM_W     = 7;
  localparam int unsigned DIM_MAX   = (1 << DIM_W) - 1;
  localparam int unsigned PIX_W     = 24;
  localparam int unsigned OUT_CNT_W = 13;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic store;
    logic start;
    logic issue;
    logic mul;
    logic decide;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic last_depth;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### design/bopm_ram.sv
`default_nettype none

module bopm_ram #(
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/bopm_ctrl.sv
`default_nettype none

module bopm_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   last_pixel_i,
  output logic                        in_ready_o,
  input  wire bopm_pkg::dp_status_t   status_i,
  output bopm_pkg::ctrl_cmd_t         cmd_o
);

  bopm_pkg::state_e state_q, state_d;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bopm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    unique case (state_q)
      bopm_pkg::ST_IDLE: begin
        in_ready_o = !(last_pixel_i && status_i.out_busy);
        accept     = in_valid_i && in_ready_o;
        cmd_o.store = accept;
        if (accept && last_pixel_i) begin
          cmd_o.start = 1'b1;
          state_d     = bopm_pkg::ST_SCAN;
        end
      end
      bopm_pkg::ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = bopm_pkg::ST_DRAIN;
        end
      end
      bopm_pkg::ST_DRAIN: begin
        state_d = bopm_pkg::ST_MUL;
      end
      bopm_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = bopm_pkg::ST_DECIDE;
      end
      bopm_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = status_i.last_depth ? bopm_pkg::ST_FINISH : bopm_pkg::ST_SCAN;
      end
      bopm_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = bopm_pkg::ST_IDLE;
      end
      default: begin
        state_d = bopm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/bopm_dp.sv
`default_nettype none

module bopm_dp #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bopm_pkg::ctrl_cmd_t           cmd_i,
  output bopm_pkg::dp_status_t               status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [bopm_pkg::DIM_W-1:0]    cfg_data_i,
  input  wire logic                          opcode_i,
  input  wire logic [bopm_pkg::PIX_W-1:0]    pixel_rgb_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [bopm_pkg::DIM_W-1:0]         overlap_rows_o,
  output logic [bopm_pkg::OUT_CNT_W-1:0]     matched_pixels_o
);

  localparam int unsigned CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned PROD_W = CNT_W + bopm_pkg::DIM_W;
  localparam int unsigned WCAP   = (MAX_WIDTH < bopm_pkg::DIM_MAX) ? MAX_WIDTH : bopm_pkg::DIM_MAX;
  localparam int unsigned HCAP   = (MAX_HEIGHT < bopm_pkg::DIM_MAX) ? MAX_HEIGHT : bopm_pkg::DIM_MAX;
  localparam int unsigned W_RST  = (WCAP < 64) ? WCAP : 64;
  localparam int unsigned H_RST  = (HCAP < 64) ? HCAP : 64;

  function automatic logic [bopm_pkg::DIM_W-1:0] clamp_dim(
    input logic [bopm_pkg::DIM_W-1:0] v,
    input logic [bopm_pkg::DIM_W-1:0] cap
  );
    logic [bopm_pkg::DIM_W-1:0] r;
    if (v == '0) begin
      r = bopm_pkg::DIM_W'(1);
    end else if (v > cap) begin
      r = cap;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [bopm_pkg::DIM_W-1:0]   w_q, h_q;
  logic [CNT_W-1:0]             w_ext;
  logic [CNT_W-1:0]             limit;
  logic [CNT_W-1:0]             up_cnt_q, lo_cnt_q;
  logic                         up_we, lo_we;
  logic [CNT_W-1:0]             la_q, ua_q, base_q, lim_q, acc_q;
  logic [bopm_pkg::DIM_W-1:0]   depth_q;
  logic [bopm_pkg::DIM_W-1:0]   best_depth_q;
  logic [CNT_W-1:0]             best_cnt_q;
  logic [PROD_W-1:0]            prod_new_q, prod_old_q;
  logic                         rd_vld_q;
  logic                         out_valid_q;
  logic [bopm_pkg::PIX_W-1:0]   up_rdata, lo_rdata;
  logic                         hit, better;

  assign w_ext = CNT_W'(w_q);
  assign limit = CNT_W'(w_q * h_q);

  assign up_we = cmd_i.store && !opcode_i && (up_cnt_q < limit);
  assign lo_we = cmd_i.store &&  opcode_i && (lo_cnt_q < limit);

  bopm_ram #(
    .WIDTH (bopm_pkg::PIX_W),
    .DEPTH (CELLS),
    .ADDR_W(ADDR_W)
  ) u_upper_ram (
    .clk_i  (clk_i),
    .we_i   (up_we),
    .waddr_i(up_cnt_q[ADDR_W-1:0]),
    .wdata_i(pixel_rgb_i),
    .raddr_i(ua_q[ADDR_W-1:0]),
    .rdata_o(up_rdata)
  );

  bopm_ram #(
    .WIDTH (bopm_pkg::PIX_W),
    .DEPTH (CELLS),
    .ADDR_W(ADDR_W)
  ) u_lower_ram (
    .clk_i  (clk_i),
    .we_i   (lo_we),
    .waddr_i(lo_cnt_q[ADDR_W-1:0]),
    .wdata_i(pixel_rgb_i),
    .raddr_i(la_q[ADDR_W-1:0]),
    .rdata_o(lo_rdata)
  );

  assign hit    = rd_vld_q && (up_rdata == lo_rdata);
  assign better = (best_depth_q == '0) ? (acc_q != '0) : (prod_new_q > prod_old_q);

  assign status_o.scan_last  = (la_q == (lim_q - CNT_W'(1)));
  assign status_o.last_depth = (depth_q == h_q);
  assign status_o.out_busy   = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q          <= bopm_pkg::DIM_W'(W_RST);
      h_q          <= bopm_pkg::DIM_W'(H_RST);
      up_cnt_q     <= '0;
      lo_cnt_q     <= '0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      best_depth_q <= '0;
      best_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == bopm_pkg::REG_FRAME_WIDTH) begin
          w_q <= clamp_dim(cfg_data_i, bopm_pkg::DIM_W'(WCAP));
        end else begin
          h_q <= clamp_dim(cfg_data_i, bopm_pkg::DIM_W'(HCAP));
        end
      end
      if (cmd_i.start) begin
        up_cnt_q <= '0;
        lo_cnt_q <= '0;
      end else begin
        if (up_we) begin
          up_cnt_q <= up_cnt_q + CNT_W'(1);
        end
        if (lo_we) begin
          lo_cnt_q <= lo_cnt_q + CNT_W'(1);
        end
      end
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        best_depth_q <= '0;
        best_cnt_q   <= '0;
      end else if (cmd_i.decide && better) begin
        best_depth_q <= depth_q;
        best_cnt_q   <= acc_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      depth_q <= bopm_pkg::DIM_W'(1);
      la_q    <= '0;
      lim_q   <= w_ext;
      base_q  <= limit - w_ext;
      ua_q    <= limit - w_ext;
    end else if (cmd_i.decide) begin
      depth_q <= depth_q + bopm_pkg::DIM_W'(1);
      la_q    <= '0;
      lim_q   <= lim_q + w_ext;
      base_q  <= base_q - w_ext;
      ua_q    <= base_q - w_ext;
    end else if (cmd_i.issue) begin
      la_q <= la_q + CNT_W'(1);
      ua_q <= ua_q + CNT_W'(1);
    end
    if (cmd_i.start || cmd_i.decide) begin
      acc_q <= '0;
    end else if (hit) begin
      acc_q <= acc_q + CNT_W'(1);
    end
    if (cmd_i.mul) begin
      prod_new_q <= PROD_W'(acc_q * best_depth_q);
      prod_old_q <= PROD_W'(best_cnt_q * depth_q);
    end
    if (cmd_i.finish) begin
      overlap_rows_o   <= best_depth_q;
      matched_pixels_o <= bopm_pkg::OUT_CNT_W'(best_cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### design/best_overlap_by_pixel_match_unit.sv
`default_nettype none

// Loads an upper and a lower RGB frame one pixel per cycle while no search runs,
// then searches every overlap depth from 1 to the frame height and returns the
// depth with the best match ratio (0 if no pixel matched) and its match count.
// The search is bounded by one read of each frame memory per cycle: depth h
// scans h*width pixel pairs, then compares ratios. Pixel transfers continue
// while a result waits; a last pixel is held off until the previous result's
// transfer. Configuration writes take effect at once and belong between
// searches.
module best_overlap_by_pixel_match_unit #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [bopm_pkg::DIM_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          opcode_i,
  input  wire logic [bopm_pkg::PIX_W-1:0]    pixel_rgb_i,
  input  wire logic                          last_pixel_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [bopm_pkg::DIM_W-1:0]         overlap_rows_o,
  output logic [bopm_pkg::OUT_CNT_W-1:0]     matched_pixels_o
);

  bopm_pkg::ctrl_cmd_t  cmd;
  bopm_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  bopm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_pixel_i(last_pixel_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bopm_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .pixel_rgb_i     (pixel_rgb_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .overlap_rows_o  (overlap_rows_o),
    .matched_pixels_o(matched_pixels_o)
  );

endmodule

`default_nettype wire

### verif/best_overlap_by_pixel_match_unit_tb.sv
`timescale 1ns / 100ps

module best_overlap_by_pixel_match_unit_tb;

  localparam int unsigned FRAME_MAX  = 64;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [bopm_pkg::DIM_W-1:0]     rows;
    logic [bopm_pkg::OUT_CNT_W-1:0] hits;
  } overlap_t;

  typedef enum {
    FRAME_CLEAN,
    FRAME_EXTRA,
    FRAME_SHORT,
    FRAME_UPPER_LAST,
    FRAME_MIXED,
    FRAME_NOISE
  } frame_kind_e;

  class overlap_scoreboard;
    logic [bopm_pkg::PIX_W-1:0] upper_px[FRAME_MAX*FRAME_MAX];
    logic [bopm_pkg::PIX_W-1:0] lower_px[FRAME_MAX*FRAME_MAX];
    int unsigned      upper_cnt = 0;
    int unsigned      lower_cnt = 0;
    int unsigned      upper_hw  = 0;
    int unsigned      lower_hw  = 0;
    logic [bopm_pkg::DIM_W-1:0] width_reg  = 7'd64;
    logic [bopm_pkg::DIM_W-1:0] height_reg = 7'd64;
    overlap_t         expected_q[$];
    int               errors  = 0;
    int               results = 0;

    function int unsigned eff_dim(logic [bopm_pkg::DIM_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > FRAME_MAX) return FRAME_MAX;
      return 32'(raw);
    endfunction

    function int unsigned frame_cells();
      return eff_dim(width_reg) * eff_dim(height_reg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // true when a search started by this pixel reads only entries written since reset
    function bit search_safe(bit op);
      int unsigned cells;
      int unsigned u;
      int unsigned l;
      cells = frame_cells();
      u = upper_cnt;
      l = lower_cnt;
      if (!op && u < cells) u++;
      if (op && l < cells) l++;
      if (upper_hw > u) u = upper_hw;
      if (lower_hw > l) l = lower_hw;
      return (u >= cells) && (l >= cells);
    endfunction

    function void note_config(logic idx, logic [bopm_pkg::DIM_W-1:0] val);
      if (idx == bopm_pkg::REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function void note_pixel(bit op, logic [bopm_pkg::PIX_W-1:0] pix, bit last);
      int unsigned w;
      int unsigned hgt;
      int unsigned cells;
      longint      hits;
      overlap_t    best;
      w     = eff_dim(width_reg);
      hgt   = eff_dim(height_reg);
      cells = w * hgt;
      if (!op && upper_cnt < cells) begin
        upper_px[upper_cnt] = pix;
        upper_cnt++;
        if (upper_cnt > upper_hw) upper_hw = upper_cnt;
      end else if (op && lower_cnt < cells) begin
        lower_px[lower_cnt] = pix;
        lower_cnt++;
        if (lower_cnt > lower_hw) lower_hw = lower_cnt;
      end
      if (!last) return;
      best = '0;
      for (int d = 1; d <= hgt; d++) begin
        hits = 0;
        for (int y = 0; y < d; y++)
          for (int x = 0; x < w; x++)
            if (upper_px[(hgt - d + y) * w + x] == lower_px[y * w + x]) hits++;
        if (best.rows == 0 ? hits > 0 : hits * best.rows > longint'(best.hits) * d) begin
          best.rows = bopm_pkg::DIM_W'(d);
          best.hits = bopm_pkg::OUT_CNT_W'(hits);
        end
      end
      expected_q.push_back(best);
      upper_cnt = 0;
      lower_cnt = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [bopm_pkg::DIM_W-1:0] rows, logic [bopm_pkg::OUT_CNT_W-1:0] hits);
      overlap_t exp_res;
      results++;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: rows=%0d matches=%0d", rows, hits));
        return;
      end
      exp_res = expected_q.pop_front();
      if (rows !== exp_res.rows)
        report($sformatf("overlap_rows %0d, want %0d", rows, exp_res.rows));
      if (hits !== exp_res.hits)
        report($sformatf("matched_pixels %0d, want %0d", hits, exp_res.hits));
    endtask
  endclass

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           cfg_valid_i  = 1'b0;
  logic                           cfg_ready_o;
  logic                           cfg_index_i  = 1'b0;
  logic [bopm_pkg::DIM_W-1:0]     cfg_data_i   = '0;
  logic                           in_valid_i   = 1'b0;
  logic                           in_ready_o;
  logic                           opcode_i     = 1'b0;
  logic [bopm_pkg::PIX_W-1:0]     pixel_rgb_i  = '0;
  logic                           last_pixel_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i  = 1'b0;
  logic [bopm_pkg::DIM_W-1:0]     overlap_rows_o;
  logic [bopm_pkg::OUT_CNT_W-1:0] matched_pixels_o;

  overlap_scoreboard sb;
  bit                steady      = 1'b0;
  int                pixels_sent = 0;
  int                idle_cycles = 0;

  best_overlap_by_pixel_match_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .pixel_rgb_i      (pixel_rgb_i),
    .last_pixel_i     (last_pixel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .overlap_rows_o   (overlap_rows_o),
    .matched_pixels_o (matched_pixels_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(overlap_rows_o, matched_pixels_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_pixel(bit op, logic [bopm_pkg::PIX_W-1:0] pix, bit last);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    pixel_rgb_i  <= pix;
    last_pixel_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(op, pix, last);
    pixels_sent++;
  endtask

  // hold input until every pending result has been transferred
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_frame(logic [bopm_pkg::DIM_W-1:0] w, logic [bopm_pkg::DIM_W-1:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= bopm_pkg::REG_FRAME_WIDTH;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(bopm_pkg::REG_FRAME_WIDTH, w);
    cfg_index_i <= bopm_pkg::REG_FRAME_HEIGHT;
    cfg_data_i  <= h;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(bopm_pkg::REG_FRAME_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_frame(frame_kind_e kind);
    int unsigned                w;
    int unsigned                h;
    int unsigned                cells;
    int unsigned                n;
    int unsigned                d;
    bit                         want_last;
    logic [bopm_pkg::PIX_W-1:0] palette[4];
    logic [bopm_pkg::PIX_W-1:0] upper_img[$];
    logic [bopm_pkg::PIX_W-1:0] lower_img[$];
    bit                         seq_op[$];
    logic [bopm_pkg::PIX_W-1:0] seq_px[$];
    w     = sb.eff_dim(sb.width_reg);
    h     = sb.eff_dim(sb.height_reg);
    cells = w * h;
    foreach (palette[i]) palette[i] = bopm_pkg::PIX_W'($urandom());
    for (int i = 0; i < cells; i++) upper_img.push_back(palette[$urandom_range(3)]);
    // seed an overlap of depth d, with a little noise
    d = $urandom_range(h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        lower_img.push_back((y < d && $urandom_range(9) != 0) ?
                            upper_img[(h - d + y) * w + x] : palette[$urandom_range(3)]);
    want_last = 1'b1;
    case (kind)
      FRAME_CLEAN, FRAME_EXTRA, FRAME_SHORT: begin
        foreach (upper_img[i]) begin
          seq_op.push_back(1'b0);
          seq_px.push_back(upper_img[i]);
        end
        n = (kind == FRAME_SHORT && cells > 1) ? $urandom_range(1, cells - 1) : cells;
        for (int i = 0; i < n; i++) begin
          seq_op.push_back(1'b1);
          seq_px.push_back(lower_img[i]);
        end
        if (kind == FRAME_EXTRA) begin
          repeat ($urandom_range(1, 4)) begin
            seq_op.push_back(1'($urandom_range(1)));
            seq_px.push_back(bopm_pkg::PIX_W'($urandom()));
          end
        end
      end
      FRAME_UPPER_LAST: begin
        foreach (lower_img[i]) begin
          seq_op.push_back(1'b1);
          seq_px.push_back(lower_img[i]);
        end
        foreach (upper_img[i]) begin
          seq_op.push_back(1'b0);
          seq_px.push_back(upper_img[i]);
        end
      end
      FRAME_MIXED: begin
        for (int i = 0; i < 2 * cells; i++) begin
          seq_op.push_back(1'($urandom_range(1)));
          seq_px.push_back($urandom_range(1) ? upper_img[$urandom_range(cells - 1)] :
                                               lower_img[$urandom_range(cells - 1)]);
        end
      end
      default: begin
        want_last = 1'b0;
        repeat ($urandom_range(1, 6)) begin
          seq_op.push_back(1'($urandom_range(1)));
          seq_px.push_back(bopm_pkg::PIX_W'($urandom()));
        end
      end
    endcase
    foreach (seq_op[i])
      send_pixel(seq_op[i], seq_px[i],
                 want_last && i == seq_op.size() - 1 && sb.search_safe(seq_op[i]));
  endtask

  initial begin
    logic [bopm_pkg::DIM_W-1:0] raw_w[5];
    logic [bopm_pkg::DIM_W-1:0] raw_h[5];
    logic [bopm_pkg::DIM_W-1:0] w;
    logic [bopm_pkg::DIM_W-1:0] h;
    int               phase;
    int               frames;
    int               pick;
    frame_kind_e      kind;
    sb = new();
    raw_w = '{7'd127, 7'd1, 7'd65, 7'd0, 7'd64};
    raw_h = '{7'd1, 7'd127, 7'd3, 7'd0, 7'd2};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-pixel frames: both extremes of the pixel value, upper-last,
    // overflow pixels, and a search over an old upper frame
    program_frame(7'd0, 7'd0);
    send_pixel(1'b0, 24'h000000, 1'b0);
    send_pixel(1'b1, 24'h000000, 1'b1);
    send_pixel(1'b0, 24'hFFFFFF, 1'b0);
    send_pixel(1'b1, 24'hFFFFFE, 1'b1);
    send_pixel(1'b1, 24'hFFFFFF, 1'b0);
    send_pixel(1'b0, 24'hFFFFFF, 1'b1);
    send_pixel(1'b0, 24'h123456, 1'b0);
    send_pixel(1'b0, 24'h654321, 1'b0);
    send_pixel(1'b1, 24'h123456, 1'b0);
    send_pixel(1'b1, 24'hABCDEF, 1'b1);
    send_pixel(1'b1, 24'h123456, 1'b1);

    phase = 0;
    while (pixels_sent < 1500) begin
      wait_drained();
      if (phase < 5) begin
        w = raw_w[phase];
        h = raw_h[phase];
        frames = 1;
      end else if ($urandom_range(7) == 0) begin
        w = bopm_pkg::DIM_W'($urandom_range(127));
        h = bopm_pkg::DIM_W'($urandom_range(2));
        frames = $urandom_range(1, 3);
      end else begin
        w = bopm_pkg::DIM_W'($urandom_range(1, 8));
        h = bopm_pkg::DIM_W'($urandom_range(1, 8));
        frames = $urandom_range(2, 6);
      end
      program_frame(w, h);
      steady = (phase == 6);
      repeat (frames) begin
        pick = $urandom_range(99);
        if (pick < 55) kind = FRAME_CLEAN;
        else if (pick < 63) kind = FRAME_EXTRA;
        else if (pick < 71) kind = FRAME_SHORT;
        else if (pick < 79) kind = FRAME_UPPER_LAST;
        else if (pick < 89) kind = FRAME_MIXED;
        else kind = FRAME_NOISE;
        send_frame(kind);
        if ($urandom_range(9) == 0) wait_drained();
      end
      phase++;
    end
    steady = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/bopm_pkg.sv
design/bopm_ram.sv
design/bopm_ctrl.sv
design/bopm_dp.sv
design/best_overlap_by_pixel_match_unit.sv
verif/best_overlap_by_pixel_match_unit_tb.sv
